### hdl/tofcpf_pkg.sv
// Shared types, constants and widths for the time-of-flight coincidence point finder.
`timescale 1ns / 1ps
package tofcpf_pkg;

	localparam int DEF_WINDOW_DEPTH = 16;

	localparam int TIME_W     = 48;
	localparam int ENERGY_W   = 11;
	localparam int POS_W      = 18;
	localparam int COINC_W    = 16;
	localparam int HOLD_W     = 20;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int SLOT_OUT_W = 4;

	localparam int SQRT_STEPS = 27;
	localparam int DIV_STEPS  = 22;
	localparam int ITER_W     = 5;

	localparam logic [19:0] HALF_C_Q16 = 20'd628710;

	localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COINC       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD        = 2'd3;

	localparam logic [ENERGY_W-1:0] RST_ENERGY_LOW  = 11'd400;
	localparam logic [ENERGY_W-1:0] RST_ENERGY_HIGH = 11'd600;
	localparam logic [COINC_W-1:0]  RST_COINC       = 16'd200;
	localparam logic [HOLD_W-1:0]   RST_HOLD        = 20'd1000;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0]          time_ps;
		logic [ENERGY_W-1:0]        energy;
		logic signed [POS_W-1:0]    x;
		logic signed [POS_W-1:0]    y;
		logic signed [POS_W-1:0]    z;
	} hit_t;

	typedef struct packed {
		logic       hit_load;
		logic       wr_en;
		logic       pair_latch;
		logic       sq_en;
		logic       sum_en;
		logic       sqrt_init;
		logic       sqrt_step;
		logic [1:0] axis;
		logic       mul1_en;
		logic       mul2_en;
		logic       div_init;
		logic       div_step;
		logic       axis_done;
		logic       pend_load;
		logic       out_load;
		logic       out_from_pend;
		logic       out_last;
		logic       ovf;
	} cmd_t;

	typedef struct packed {
		logic evict;
		logic pass;
		logic axis_skip;
	} sts_t;

endpackage

### hdl/tof_coincidence_point_finder_unit.sv
// Top level of the time-of-flight coincidence point finder.
`timescale 1ns / 1ps
// Takes one detector hit per transfer and works on it alone: in_stall stays high until every
// result of that hit has gone into the output register. A hit's work is the eviction tests on
// the window, a check of each stored hit, and for every passing pair a 27-step square root
// shared by all three axes plus a 22-step divide per axis, skipped for an axis with no offset;
// a stalled output register holds the flow.
// Each hit yields one result per passing pair (last on the final one) or a single found=0 result.
module tof_coincidence_point_finder_unit import tofcpf_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [TIME_W-1:0]        hit_time,
	input  logic [ENERGY_W-1:0]      hit_energy,
	input  logic signed [POS_W-1:0]  hit_x,
	input  logic signed [POS_W-1:0]  hit_y,
	input  logic signed [POS_W-1:0]  hit_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     found,
	output logic signed [POS_W-1:0]  point_x,
	output logic signed [POS_W-1:0]  point_y,
	output logic signed [POS_W-1:0]  point_z,
	output logic [SLOT_OUT_W-1:0]    partner_slot,
	output logic                     overflow,
	output logic                     last
);

	localparam int SLOT_W = $clog2(WINDOW_DEPTH);

	cmd_t              cmd;
	sts_t              sts;
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] wr_addr;

	tofcpf_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr)
	);

	tofcpf_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.hit_time     (hit_time),
		.hit_energy   (hit_energy),
		.hit_x        (hit_x),
		.hit_y        (hit_y),
		.hit_z        (hit_z),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.wr_addr      (wr_addr),
		.sts          (sts),
		.found        (found),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.partner_slot (partner_slot),
		.overflow     (overflow),
		.last         (last)
	);

endmodule

### hdl/tofcpf_dp.sv
// Datapath: config registers, hit window memory, square root, divider and point assembly.
`timescale 1ns / 1ps
module tofcpf_dp import tofcpf_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	localparam int SLOT_W = $clog2(WINDOW_DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic [TIME_W-1:0]          hit_time,
	input  logic [ENERGY_W-1:0]        hit_energy,
	input  logic signed [POS_W-1:0]    hit_x,
	input  logic signed [POS_W-1:0]    hit_y,
	input  logic signed [POS_W-1:0]    hit_z,
	input  cmd_t                       cmd,
	input  logic [SLOT_W-1:0]          rd_addr,
	input  logic [SLOT_W-1:0]          wr_addr,
	output sts_t                       sts,
	output logic                       found,
	output logic signed [POS_W-1:0]    point_x,
	output logic signed [POS_W-1:0]    point_y,
	output logic signed [POS_W-1:0]    point_z,
	output logic [SLOT_OUT_W-1:0]      partner_slot,
	output logic                       overflow,
	output logic                       last
);

	logic [ENERGY_W-1:0] energy_low_q;
	logic [ENERGY_W-1:0] energy_high_q;
	logic [COINC_W-1:0]  coinc_q;
	logic [HOLD_W-1:0]   hold_q;

	hit_t hit_q;
	hit_t rd_q;
	hit_t win_mem [WINDOW_DEPTH];

	logic signed [POS_W:0] dx_q, dy_q, dz_q;
	logic signed [POS_W:0] sx_q, sy_q, sz_q;
	logic [COINC_W-1:0]    adt_q;
	logic                  dt_neg_q;
	logic [SLOT_W-1:0]     slot_q;

	logic [36:0] sqx_q, sqy_q, sqz_q;
	logic [37:0] dd_q;
	logic [53:0] sv_q;
	logic [28:0] srem_q;
	logic [26:0] root_q;

	logic [33:0] p1_q;
	logic [53:0] p2_q;
	logic [35:0] dvs_q;
	logic [35:0] drem_q;
	logic [21:0] dnum_q;
	logic [21:0] quo_q;

	logic signed [POS_W-1:0] pt_x_q, pt_y_q, pt_z_q;
	logic signed [POS_W-1:0] pend_x_q, pend_y_q, pend_z_q;
	logic [SLOT_W-1:0]       pend_slot_q;

	logic [TIME_W:0]        age;
	logic [TIME_W:0]        dt_full;
	logic [TIME_W:0]        adt_full;
	logic signed [POS_W:0]  d_sel;
	logic signed [POS_W:0]  s_sel;
	logic [POS_W-1:0]       ad;
	logic signed [37:0]     sqx_w, sqy_w, sqz_w;
	logic [30:0]            s_trial_rem;
	logic [30:0]            s_trial;
	logic                   s_ge;
	logic [56:0]            num;
	logic [36:0]            d_trial;
	logic                   d_ge;
	logic signed [23:0]     off;
	logic signed [23:0]     tot;
	logic signed [23:0]     half;
	logic signed [POS_W-1:0] pt_new;
	logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

	function automatic logic e_ok(input logic [ENERGY_W-1:0] e,
			input logic [ENERGY_W-1:0] lo, input logic [ENERGY_W-1:0] hi);
		return (e >= lo) && (e <= hi);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_low_q  <= RST_ENERGY_LOW;
			energy_high_q <= RST_ENERGY_HIGH;
			coinc_q       <= RST_COINC;
			hold_q        <= RST_HOLD;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ENERGY_LOW:  energy_low_q  <= cfg_data[ENERGY_W-1:0];
				CFG_ENERGY_HIGH: energy_high_q <= cfg_data[ENERGY_W-1:0];
				CFG_COINC:       coinc_q       <= cfg_data[COINC_W-1:0];
				CFG_HOLD:        hold_q        <= cfg_data[HOLD_W-1:0];
				default:         hold_q        <= hold_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			win_mem[wr_addr] <= hit_q;
		end
		rd_q <= win_mem[rd_addr];
	end

	always_comb begin
		age      = {1'b0, hit_q.time_ps} - {1'b0, rd_q.time_ps};
		dt_full  = {1'b0, rd_q.time_ps} - {1'b0, hit_q.time_ps};
		adt_full = dt_full[TIME_W] ? (~dt_full + 1'b1) : dt_full;
		sts.evict = $signed(age) > $signed({1'b0, hold_q});
		sts.pass  = e_ok(rd_q.energy, energy_low_q, energy_high_q)
			&& e_ok(hit_q.energy, energy_low_q, energy_high_q)
			&& (adt_full <= {{(TIME_W+1-COINC_W){1'b0}}, coinc_q});

		case (cmd.axis)
			AX_X: begin d_sel = dx_q; s_sel = sx_q; end
			AX_Y: begin d_sel = dy_q; s_sel = sy_q; end
			default: begin d_sel = dz_q; s_sel = sz_q; end
		endcase
		ad = d_sel[POS_W] ? POS_W'(-d_sel) : d_sel[POS_W-1:0];
		sts.axis_skip = (d_sel == '0) || (adt_q == '0);

		sqx_w = dx_q * dx_q;
		sqy_w = dy_q * dy_q;
		sqz_w = dz_q * dz_q;

		s_trial_rem = {srem_q, sv_q[53:52]};
		s_trial     = {2'b00, root_q, 2'b01};
		s_ge        = s_trial_rem >= s_trial;

		num     = {1'b0, p2_q, 2'b00} + {22'd0, root_q, 8'd0};
		d_trial = {drem_q, dnum_q[21]};
		d_ge    = d_trial >= {1'b0, dvs_q};

		if (sts.axis_skip) begin
			off = '0;
		end else if (d_sel[POS_W] ^ dt_neg_q) begin
			off = -$signed({2'b00, quo_q});
		end else begin
			off = $signed({2'b00, quo_q});
		end
		tot  = 24'(s_sel) + off;
		half = tot >>> 1;
		if (half > 24'sd131071) begin
			pt_new = 18'sd131071;
		end else if (half < -24'sd131072) begin
			pt_new = -18'sd131072;
		end else begin
			pt_new = half[POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hit_load) begin
			hit_q <= '{time_ps: hit_time, energy: hit_energy, x: hit_x, y: hit_y, z: hit_z};
		end
		if (cmd.pair_latch) begin
			dx_q     <= 19'(hit_q.x) - 19'(rd_q.x);
			dy_q     <= 19'(hit_q.y) - 19'(rd_q.y);
			dz_q     <= 19'(hit_q.z) - 19'(rd_q.z);
			sx_q     <= 19'(hit_q.x) + 19'(rd_q.x);
			sy_q     <= 19'(hit_q.y) + 19'(rd_q.y);
			sz_q     <= 19'(hit_q.z) + 19'(rd_q.z);
			adt_q    <= adt_full[COINC_W-1:0];
			dt_neg_q <= dt_full[TIME_W];
			slot_q   <= rd_addr;
		end
		if (cmd.sq_en) begin
			sqx_q <= sqx_w[36:0];
			sqy_q <= sqy_w[36:0];
			sqz_q <= sqz_w[36:0];
		end
		if (cmd.sum_en) begin
			dd_q <= 38'(sqx_q) + 38'(sqy_q) + 38'(sqz_q);
		end
		if (cmd.sqrt_init) begin
			sv_q   <= {dd_q, 16'd0};
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			srem_q <= s_ge ? 29'(s_trial_rem - s_trial) : s_trial_rem[28:0];
			root_q <= {root_q[25:0], s_ge};
			sv_q   <= {sv_q[51:0], 2'b00};
		end
		if (cmd.mul1_en) begin
			p1_q <= ad * adt_q;
		end
		if (cmd.mul2_en) begin
			p2_q <= p1_q * HALF_C_Q16;
		end
		if (cmd.div_init) begin
			dvs_q  <= {root_q, 9'd0};
			drem_q <= {1'b0, num[56:22]};
			dnum_q <= num[21:0];
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			drem_q <= d_ge ? 36'(d_trial - {1'b0, dvs_q}) : d_trial[35:0];
			quo_q  <= {quo_q[20:0], d_ge};
			dnum_q <= {dnum_q[20:0], 1'b0};
		end
		if (cmd.axis_done) begin
			case (cmd.axis)
				AX_X:    pt_x_q <= pt_new;
				AX_Y:    pt_y_q <= pt_new;
				default: pt_z_q <= pt_new;
			endcase
		end
		if (cmd.pend_load) begin
			pend_x_q    <= pt_x_q;
			pend_y_q    <= pt_y_q;
			pend_z_q    <= pt_z_q;
			pend_slot_q <= slot_q;
		end
	end

	assign slot_ext = {{SLOT_OUT_W{1'b0}}, pend_slot_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			overflow <= cmd.ovf;
			last     <= cmd.out_last;
			if (cmd.out_from_pend) begin
				found        <= 1'b1;
				point_x      <= pend_x_q;
				point_y      <= pend_y_q;
				point_z      <= pend_z_q;
				partner_slot <= slot_ext[SLOT_OUT_W-1:0];
			end else begin
				found        <= 1'b0;
				point_x      <= '0;
				point_y      <= '0;
				point_z      <= '0;
				partner_slot <= '0;
			end
		end
	end

endmodule

### hdl/tofcpf_ctrl.sv
// Controller: window pointers, per-hit sequencing and output handshake.
`timescale 1ns / 1ps
module tofcpf_ctrl import tofcpf_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	localparam int SLOT_W = $clog2(WINDOW_DEPTH),
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  sts_t              sts,
	output cmd_t              cmd,
	output logic [SLOT_W-1:0] rd_addr,
	output logic [SLOT_W-1:0] wr_addr
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_EV_RD  = 5'd1;
	localparam logic [4:0] S_EV_CMP = 5'd2;
	localparam logic [4:0] S_OVF    = 5'd3;
	localparam logic [4:0] S_PR_RD  = 5'd4;
	localparam logic [4:0] S_PR_CHK = 5'd5;
	localparam logic [4:0] S_SQ     = 5'd6;
	localparam logic [4:0] S_SUM    = 5'd7;
	localparam logic [4:0] S_SQI    = 5'd8;
	localparam logic [4:0] S_SQRT   = 5'd9;
	localparam logic [4:0] S_MUL1   = 5'd10;
	localparam logic [4:0] S_MUL2   = 5'd11;
	localparam logic [4:0] S_DIVI   = 5'd12;
	localparam logic [4:0] S_DIV    = 5'd13;
	localparam logic [4:0] S_AXD    = 5'd14;
	localparam logic [4:0] S_PEND   = 5'd15;
	localparam logic [4:0] S_FIN    = 5'd16;

	localparam logic [CNT_W:0] DEPTH_X = (CNT_W+1)'(WINDOW_DEPTH);

	logic [4:0]        state_q, state_d;
	logic [SLOT_W-1:0] oldest_q, oldest_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [ITER_W-1:0] it_q, it_d;
	logic [1:0]        axis_q, axis_d;
	logic              ovf_q, ovf_d;
	logic              pend_q, pend_d;
	logic              out_valid_q, out_valid_d;

	logic [CNT_W:0]    rd_sum, wr_sum;
	logic [SLOT_W-1:0] oldest_inc;
	logic              out_free;

	always_comb begin
		rd_sum  = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(idx_q);
		wr_sum  = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(count_q);
		if (rd_sum >= DEPTH_X) begin
			rd_sum = rd_sum - DEPTH_X;
		end
		if (wr_sum >= DEPTH_X) begin
			wr_sum = wr_sum - DEPTH_X;
		end
		rd_addr    = rd_sum[SLOT_W-1:0];
		wr_addr    = wr_sum[SLOT_W-1:0];
		oldest_inc = (oldest_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
		out_free   = !out_valid_q || !out_stall;
	end

	always_comb begin
		state_d     = state_q;
		oldest_d    = oldest_q;
		count_d     = count_q;
		idx_d       = idx_q;
		it_d        = it_q;
		axis_d      = axis_q;
		ovf_d       = ovf_q;
		pend_d      = pend_q;
		out_valid_d = out_valid_q && out_stall;
		cmd         = '0;
		cmd.axis    = axis_q;
		cmd.ovf     = ovf_q;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.hit_load = 1'b1;
					ovf_d   = 1'b0;
					idx_d   = '0;
					state_d = (count_q != '0) ? S_EV_RD : S_OVF;
				end
			end
			S_EV_RD: state_d = S_EV_CMP;
			S_EV_CMP: begin
				if (sts.evict) begin
					oldest_d = oldest_inc;
					count_d  = count_q - 1'b1;
					state_d  = (count_q != CNT_W'(1)) ? S_EV_RD : S_OVF;
				end else begin
					state_d = S_OVF;
				end
			end
			S_OVF: begin
				if (count_q == CNT_W'(WINDOW_DEPTH)) begin
					oldest_d = oldest_inc;
					count_d  = CNT_W'(WINDOW_DEPTH - 1);
					ovf_d    = 1'b1;
				end
				idx_d   = '0;
				state_d = S_PR_RD;
			end
			S_PR_RD: state_d = (idx_q == count_q) ? S_FIN : S_PR_CHK;
			S_PR_CHK: begin
				cmd.pair_latch = 1'b1;
				if (sts.pass) begin
					state_d = S_SQ;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_PR_RD;
				end
			end
			S_SQ: begin
				cmd.sq_en = 1'b1;
				state_d   = S_SUM;
			end
			S_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = S_SQI;
			end
			S_SQI: begin
				cmd.sqrt_init = 1'b1;
				it_d          = '0;
				state_d       = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				it_d          = it_q + 1'b1;
				if (it_q == ITER_W'(SQRT_STEPS - 1)) begin
					axis_d  = AX_X;
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1_en = 1'b1;
				state_d     = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2_en = 1'b1;
				state_d     = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				it_d         = '0;
				state_d      = sts.axis_skip ? S_AXD : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				it_d         = it_q + 1'b1;
				if (it_q == ITER_W'(DIV_STEPS - 1)) begin
					state_d = S_AXD;
				end
			end
			S_AXD: begin
				cmd.axis_done = 1'b1;
				if (axis_q == AX_Z) begin
					state_d = S_PEND;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = S_MUL1;
				end
			end
			S_PEND: begin
				if (!pend_q) begin
					cmd.pend_load = 1'b1;
					pend_d  = 1'b1;
					idx_d   = idx_q + 1'b1;
					state_d = S_PR_RD;
				end else if (out_free) begin
					cmd.out_load      = 1'b1;
					cmd.out_from_pend = 1'b1;
					cmd.pend_load     = 1'b1;
					out_valid_d = 1'b1;
					idx_d   = idx_q + 1'b1;
					state_d = S_PR_RD;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.out_load      = 1'b1;
					cmd.out_from_pend = pend_q;
					cmd.out_last      = 1'b1;
					cmd.wr_en         = 1'b1;
					out_valid_d = 1'b1;
					pend_d  = 1'b0;
					count_d = count_q + 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			oldest_q    <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			it_q        <= '0;
			axis_q      <= AX_X;
			ovf_q       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			oldest_q    <= oldest_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			it_q        <= it_d;
			axis_q      <= axis_d;
			ovf_q       <= ovf_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW_DEPTH))
		else $error("window count above depth");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer taken while a hit is in work");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwritten before transfer");

	a_store: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && out_free |=> count_q == $past(count_q) + 1'b1)
		else $error("new hit not stored");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_q)
		else $error("pending result left behind");

endmodule
